FILE: sv/assert_macros.svh
// Assertion macros shared by the RTL of the sorted priority list.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication check.
`define SPL_ASSERT_IMPL(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);

// Next-cycle implication check.
`define SPL_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

FILE: sv/spl_pkg.sv
// Package for the sorted priority list: request/result types, codes, constants.
// No dependencies; used by spl_front, spl_back and sorted_priority_list.
package spl_pkg;

    localparam int DEPTH_DEF    = 32;
    localparam int PRIORITY_MAX = 3;
    localparam int VALUE_W      = 16;
    localparam int PRI_W        = 2;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = 1;
    localparam int QFILL_W      = 2;

    typedef enum logic [2:0] {
        ST_LISTED   = 3'd0,
        ST_INSERTED = 3'd1,
        ST_FULL     = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_BADPRI   = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_LIST   = 2'd1,
        CMD_BAD    = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        logic               mode;
        logic [VALUE_W-1:0] value;
        logic [PRI_W-1:0]   priority_req;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [VALUE_W-1:0] out_value;
        logic [PRI_W-1:0]   out_priority;
        logic               last;
    } rsp_t;

    // Classified command handed from front to back.
    typedef struct packed {
        cmd_kind_t          kind;
        logic [VALUE_W-1:0] value;
        logic [PRI_W-1:0]   pri;
    } cmd_t;

    // Back-end status seen by the top level.
    typedef struct packed {
        logic listing;
        logic full;
    } back_stat_t;

endpackage

FILE: sv/spl_front.sv
// Front end: accepts requests, classifies them, holds them in a 2-entry queue.
// Depends on spl_pkg.
module spl_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  spl_pkg::req_t    req,
    output logic             cmd_valid,
    output spl_pkg::cmd_t    cmd,
    input  logic             cmd_pop
);

    spl_pkg::cmd_t                     q_reg [spl_pkg::QUEUE_DEPTH];
    logic [spl_pkg::QPTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [spl_pkg::QPTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [spl_pkg::QFILL_W-1:0]       fill_reg, fill_next;
    spl_pkg::cmd_t                     cls;
    logic                              push;

    // classify: list, bad priority, or insert
    always_comb
    begin
        cls.value = req.value;
        cls.pri   = req.priority_req;
        if (req.mode)
            cls.kind = spl_pkg::CMD_LIST;
        else if (req.priority_req == '0 ||
                 req.priority_req > spl_pkg::PRI_W'(spl_pkg::PRIORITY_MAX))
            cls.kind = spl_pkg::CMD_BAD;
        else
            cls.kind = spl_pkg::CMD_INSERT;
    end

    assign req_stall = (fill_reg == spl_pkg::QFILL_W'(spl_pkg::QUEUE_DEPTH));
    assign push      = req_valid && !req_stall;
    assign cmd_valid = (fill_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !cmd_pop)
            fill_next = fill_reg + 1'b1;
        else if (!push && cmd_pop)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= cls;
    end

endmodule

FILE: sv/spl_back.sv
// Back end: shift-insert cell row, list sequencer and result register.
// Depends on spl_pkg.
module spl_back #(
    parameter int DEPTH = spl_pkg::DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  spl_pkg::cmd_t       cmd,
    output logic                cmd_pop,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output spl_pkg::rsp_t       rsp,
    output spl_pkg::back_stat_t stat
);

    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        BK_IDLE = 2'b01,
        BK_LIST = 2'b10
    } bk_state_t;

    bk_state_t                        state_reg, state_next;
    logic [CW-1:0]                    count_reg, count_next;
    logic [CW-1:0]                    left_reg, left_next;
    logic [spl_pkg::VALUE_W-1:0]      cell_val_reg [DEPTH];
    logic [spl_pkg::VALUE_W-1:0]      cell_val_next [DEPTH];
    logic [spl_pkg::PRI_W-1:0]        cell_pri_reg [DEPTH];
    logic [spl_pkg::PRI_W-1:0]        cell_pri_next [DEPTH];
    logic [DEPTH-1:0]                 take;
    logic                             do_insert, do_rotate, emit, out_free, is_last;
    spl_pkg::rsp_t                    rsp_reg, rsp_next;
    logic                             rsp_valid_reg;

    assign out_free     = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid    = rsp_valid_reg;
    assign rsp          = rsp_reg;
    assign stat.listing = (state_reg == BK_LIST);
    assign stat.full    = (count_reg == CW'(DEPTH));

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        left_next  = left_reg;
        do_insert  = 1'b0;
        do_rotate  = 1'b0;
        emit       = 1'b0;
        cmd_pop    = 1'b0;
        is_last    = 1'b0;
        rsp_next   = '{status: spl_pkg::ST_LISTED, out_value: '0, out_priority: '0,
                       last: 1'b1};
        case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    cmd_pop = 1'b1;
                    emit    = 1'b1;
                    case (cmd.kind)
                        spl_pkg::CMD_INSERT:
                        begin
                            if (count_reg == CW'(DEPTH))
                                rsp_next.status = spl_pkg::ST_FULL;
                            else
                            begin
                                rsp_next.status = spl_pkg::ST_INSERTED;
                                do_insert       = 1'b1;
                                count_next      = count_reg + CW'(1);
                            end
                        end
                        spl_pkg::CMD_LIST:
                        begin
                            if (count_reg == '0)
                                rsp_next.status = spl_pkg::ST_EMPTY;
                            else
                            begin
                                is_last               = (count_reg == CW'(1));
                                rsp_next.status       = spl_pkg::ST_LISTED;
                                rsp_next.out_value    = cell_val_reg[0];
                                rsp_next.out_priority = cell_pri_reg[0];
                                rsp_next.last         = is_last;
                                do_rotate             = 1'b1;
                                if (!is_last)
                                begin
                                    left_next  = count_reg - CW'(1);
                                    state_next = BK_LIST;
                                end
                            end
                        end
                        default:
                            rsp_next.status = spl_pkg::ST_BADPRI;
                    endcase
                end
            end
            BK_LIST:
            begin
                if (out_free)
                begin
                    is_last               = (left_reg == CW'(1));
                    emit                  = 1'b1;
                    do_rotate             = 1'b1;
                    rsp_next.status       = spl_pkg::ST_LISTED;
                    rsp_next.out_value    = cell_val_reg[0];
                    rsp_next.out_priority = cell_pri_reg[0];
                    rsp_next.last         = is_last;
                    left_next             = left_reg - CW'(1);
                    if (is_last)
                        state_next = BK_IDLE;
                end
            end
            default:
                state_next = BK_IDLE;
        endcase
    end

    // per-cell compare: new entry lands at or before cell i
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            take[i] = ((CW'(i) < count_reg) &&
                       ((cmd.pri < cell_pri_reg[i]) ||
                        (cmd.pri == cell_pri_reg[i] && cmd.value <= cell_val_reg[i]))) ||
                      (CW'(i) == count_reg);
        end
    end

    // cell next values: shift-insert or rotate toward cell 0
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            cell_val_next[i] = cell_val_reg[i];
            cell_pri_next[i] = cell_pri_reg[i];
        end
        if (do_insert)
        begin
            if (take[0])
            begin
                cell_val_next[0] = cmd.value;
                cell_pri_next[0] = cmd.pri;
            end
            for (int i = 1; i < DEPTH; i++)
            begin
                if (take[i] && CW'(i) <= count_reg)
                begin
                    if (take[i-1])
                    begin
                        cell_val_next[i] = cell_val_reg[i-1];
                        cell_pri_next[i] = cell_pri_reg[i-1];
                    end
                    else
                    begin
                        cell_val_next[i] = cmd.value;
                        cell_pri_next[i] = cmd.pri;
                    end
                end
            end
        end
        else if (do_rotate)
        begin
            // rotate within the valid cells; order is back after count steps
            for (int i = 0; i < DEPTH - 1; i++)
            begin
                if (CW'(i) < count_reg)
                begin
                    if (count_reg == CW'(i + 1))
                    begin
                        cell_val_next[i] = cell_val_reg[0];
                        cell_pri_next[i] = cell_pri_reg[0];
                    end
                    else
                    begin
                        cell_val_next[i] = cell_val_reg[i+1];
                        cell_pri_next[i] = cell_pri_reg[i+1];
                    end
                end
            end
            if (count_reg == CW'(DEPTH))
            begin
                cell_val_next[DEPTH-1] = cell_val_reg[0];
                cell_pri_next[DEPTH-1] = cell_pri_reg[0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            count_reg     <= '0;
            left_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            left_reg  <= left_next;
            if (out_free)
                rsp_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_val_reg <= cell_val_next;
        cell_pri_reg <= cell_pri_next;
        if (emit)
            rsp_reg <= rsp_next;
    end

endmodule

FILE: sv/sorted_priority_list.sv
// Sorted priority list: (priority, value) entries kept in ascending order.
// A request passes through the queue and then the result register before its first result shows.
// Throughput: insert and bad-priority requests 1 per cycle while rsp_stall is low; a list
// request holds the back end until its last entry, one entry per cycle while rsp_stall is low.
// Reset: asynchronous, active low; entry count and queue cleared, cell payload left as is.
`include "assert_macros.svh"

module sorted_priority_list #(
    parameter int DEPTH = spl_pkg::DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  spl_pkg::req_t  req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output spl_pkg::rsp_t  rsp
);

    // Front end: classifies each request (insert, list, bad priority) and
    // queues it; stalls only when both queue slots are taken.
    spl_pkg::cmd_t       cmd;
    logic                cmd_valid;
    logic                cmd_pop;
    spl_pkg::back_stat_t stat;

    spl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    // Back end: a row of DEPTH cells, each comparing itself with the new
    // entry in parallel, so an insert updates the whole row at once. Listing
    // rotates the valid cells toward cell 0, emitting one per cycle while
    // rsp_stall is low; after count steps the row is back in order.
    spl_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .stat      (stat)
    );

    // Checks
    `SPL_ASSERT_IMPL(a_pop_needs_valid, cmd_pop, cmd_valid, "pop from empty queue")
    `SPL_ASSERT_IMPL(a_no_pop_while_listing, stat.listing, !cmd_pop, "pop during list")
    `SPL_ASSERT_IMPL(a_status_result_form,
        rsp_valid && rsp.status != spl_pkg::ST_LISTED,
        rsp.last && rsp.out_value == '0 && rsp.out_priority == '0,
        "status result not last or not zeroed")
    `SPL_ASSERT_IMPL(a_last_listed_ends_list,
        rsp_valid && rsp.status == spl_pkg::ST_LISTED && rsp.last,
        !stat.listing, "list still running after last entry")
    `SPL_ASSERT_NEXT(a_full_drops,
        cmd_pop && cmd.kind == spl_pkg::CMD_INSERT && stat.full,
        rsp_valid && rsp.status == spl_pkg::ST_FULL, "insert on full store not dropped")

endmodule
